// File: rtl/krt_pkg.sv
// Shared constants, request and status codes, and the result record type of the keyed record table.
`default_nettype none

package krt_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam int CODE_W = 32;
    localparam int QTY_W  = 32;
    localparam int POS_W  = 7;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 3;
    localparam int ECNT_W = 8;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [QTY_W-1:0]  qty;
        logic [CODE_W-1:0] code;
    } krt_res_t;

endpackage

`default_nettype wire

// File: rtl/krt_ram.sv
// Simple dual-port record memory with one write port and one registered read port.
`default_nettype none

module krt_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 64
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/krt_ctrl.sv
// Sequencer that scans, updates and compacts the record memory one entry per cycle.
`default_nettype none

module krt_ctrl
    import krt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [REQ_W-1:0]    in_req,
    input  wire logic [CODE_W-1:0]   in_code,
    input  wire logic [QTY_W-1:0]    in_qty,
    input  wire logic [POS_W-1:0]    in_pos,
    input  wire logic                out_free,
    output logic                     res_push,
    output krt_res_t                 res,
    output logic [CW-1:0]            count,
    output logic                     mem_wr_en,
    output logic [AW-1:0]            mem_wr_addr,
    output logic [QTY_W+CODE_W-1:0]  mem_wr_data,
    output logic                     mem_rd_en,
    output logic [AW-1:0]            mem_rd_addr,
    input  wire logic [QTY_W+CODE_W-1:0] mem_rd_data
);

    localparam int ZW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_RDATA = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [QTY_W-1:0]  qty_reg, qty_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    krt_res_t          res_reg, res_next;

    logic [CODE_W-1:0] rd_code;
    logic [QTY_W-1:0]  rd_qty;
    logic [ZW-1:0]     pos_z;
    logic [ZW-1:0]     cnt_z;
    logic              key_hit;
    logic              more;

    assign rd_code = mem_rd_data[CODE_W-1:0];
    assign rd_qty  = mem_rd_data[QTY_W+CODE_W-1:CODE_W];
    assign pos_z   = ZW'(in_pos);
    assign cnt_z   = ZW'(count_reg);
    assign key_hit = cmp_vld_reg && (rd_code == code_reg);
    assign more    = idx_reg < count_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign res      = res_reg;
    assign count    = count_reg;

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        code_next    = code_reg;
        qty_next     = qty_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        res_next     = res_reg;
        res_push     = 1'b0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = cmp_idx_reg[AW-1:0];
        mem_wr_data  = {qty_reg, code_reg};
        mem_rd_en    = 1'b0;
        mem_rd_addr  = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = in_req;
                    code_next    = in_code;
                    qty_next     = in_qty;
                    idx_next     = '0;
                    cmp_vld_next = 1'b0;
                    if (in_req == REQ_READ)
                    begin
                        if (pos_z < cnt_z)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = pos_z[AW-1:0];
                            state_next  = S_RDATA;
                        end
                        else
                        begin
                            res_next   = '{status: ST_EMPTY, qty: '0, code: '0};
                            state_next = S_RESP;
                        end
                    end
                    else if ((in_req == REQ_INSERT) && (count_reg >= CW'(CAPACITY)))
                    begin
                        res_next   = '{status: ST_FULL, qty: '0, code: '0};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (key_hit)
                begin
                    case (req_reg)
                        REQ_INSERT:
                        begin
                            res_next   = '{status: ST_DUPLICATE, qty: rd_qty, code: rd_code};
                            state_next = S_RESP;
                        end
                        REQ_UPDATE:
                        begin
                            mem_wr_en  = 1'b1;
                            res_next   = '{status: ST_OK, qty: qty_reg, code: code_reg};
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            res_next     = '{status: ST_OK, qty: rd_qty, code: rd_code};
                            idx_next     = cmp_idx_reg + 1'b1;
                            cmp_vld_next = 1'b0;
                            state_next   = S_SHIFT;
                        end
                    endcase
                end
                else if (more)
                begin
                    mem_rd_en    = 1'b1;
                    cmp_idx_next = idx_reg;
                    idx_next     = idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                else if (cmp_vld_reg)
                begin
                    cmp_vld_next = 1'b0;
                end
                else if (req_reg == REQ_INSERT)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = count_reg[AW-1:0];
                    count_next  = count_reg + 1'b1;
                    res_next    = '{status: ST_OK, qty: qty_reg, code: code_reg};
                    state_next  = S_RESP;
                end
                else
                begin
                    res_next   = '{status: ST_NOT_FOUND, qty: '0, code: '0};
                    state_next = S_RESP;
                end
            end

            S_SHIFT:
            begin
                if (cmp_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = cmp_idx_reg[AW-1:0];
                    mem_wr_data = mem_rd_data;
                end
                if (more)
                begin
                    mem_rd_en    = 1'b1;
                    cmp_idx_next = idx_reg - 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_RESP;
                    end
                end
            end

            S_RDATA:
            begin
                res_next   = '{status: ST_OK, qty: rd_qty, code: rd_code};
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        code_reg    <= code_next;
        qty_reg     <= qty_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire

// File: rtl/keyed_record_table.sv
// Top level of the keyed record table: request and response channels around the sequencer and memory.
//
// One request transaction enters on the s_axis channel; tuser carries the request type and
// tdata the key, quantity and read position. Every request yields exactly one response
// transaction on the m_axis channel: tuser carries the status, tdata the record touched and
// the entry count after the operation.
// The block works on one request at a time and s_axis_tready is low while it does. A key
// search reads one stored record per cycle through the memory's registered read port. A
// removal that hits at position i stops its search there and then moves each later record
// down one place, one per cycle. A read by position or a full-table insert needs no search.
// The response sits in an output register; the next request is accepted while it waits.
// If the receiver stalls, a finished request holds in the sequencer until the register frees.
// Reset empties the table at once (the entry count goes to zero); no clearing pass is needed
// and the record memory itself is not cleared.
`default_nettype none

module keyed_record_table
    import krt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // item_code, item_quantity, slot_position, pad
    input  wire logic [1:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // found_code, found_quantity, entry_count
    output logic [2:0]       m_axis_tuser   // status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > ECNT_W) ? CW : ECNT_W;
    localparam int DW = QTY_W + CODE_W;

    logic              out_valid_reg;
    krt_res_t          out_res_reg;
    logic [ECNT_W-1:0] out_cnt_reg;

    logic              out_free;
    logic              res_push;
    krt_res_t          res;
    logic [CW-1:0]     count;
    logic [EW-1:0]     count_ext;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [DW-1:0]     mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [DW-1:0]     mem_rd_data;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign count_ext = EW'(count);

    krt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (s_axis_tuser),
        .in_code     (s_axis_tdata[31:0]),
        .in_qty      (s_axis_tdata[63:32]),
        .in_pos      (s_axis_tdata[70:64]),
        .out_free    (out_free),
        .res_push    (res_push),
        .res         (res),
        .count       (count),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    krt_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_res_reg <= res;
            out_cnt_reg <= count_ext[ECNT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cnt_reg, out_res_reg.qty, out_res_reg.code};
    assign m_axis_tuser  = out_res_reg.status;

endmodule

`default_nettype wire

// File: rtl/krt_chk.sv
// Port-level checker for the keyed record table and its bind to the top level.
`default_nettype none

module krt_chk
    import krt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [71:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > ECNT_W) ? CW : ECNT_W;
    localparam logic [EW-1:0] CAP_EXT = EW'(CAPACITY);

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("response dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while a previous one is in progress");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> m_axis_tdata[71:64] == CAP_EXT[7:0])
        else $error("table full reported below capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == ST_FULL) || (m_axis_tuser == ST_NOT_FOUND)
            || (m_axis_tuser == ST_EMPTY)) |-> m_axis_tdata[63:0] == 64'd0)
        else $error("failed request returned a record");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_EMPTY)
        else $error("undefined status code");

endmodule

bind keyed_record_table krt_chk #(.CAPACITY(CAPACITY)) u_krt_chk (.*);

`default_nettype wire
